### rtl/touch_autocal_normalizer_macros.svh
// Assertion macros for the touch point normalizer.
// Included by the top level; define NO_ASSERTIONS to drop all checks.
`ifndef TOUCH_AUTOCAL_NORMALIZER_MACROS_SVH
`define TOUCH_AUTOCAL_NORMALIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TAN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TAN_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define TAN_ASSERT(label, clk, rst_n, prop, msg)
`define TAN_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

### rtl/tan_pkg.sv
// Shared types and constants of the touch point normalizer.
// No dependencies; used by touch_autocal_normalizer.
package tan_pkg;

  localparam int RawW    = 10;  // raw reading and calibration limit width
  localparam int OutW    = 11;  // screen coordinate width
  localparam int CalcW   = 13;  // signed width of intermediate coordinates
  localparam int TopW    = 11;  // scale factor width
  localparam int ProdW   = RawW + TopW;
  localparam int DivBits = ProdW;
  localparam int CntW    = $clog2(DivBits);

  localparam logic [RawW-1:0] XLowReset  = RawW'(100);
  localparam logic [RawW-1:0] XHighReset = RawW'(900);
  localparam logic [RawW-1:0] YLowReset  = RawW'(75);
  localparam logic [RawW-1:0] YHighReset = RawW'(900);

  localparam int YOvershoot = 10;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

### rtl/touch_autocal_normalizer.sv
// Touch point normalizer with automatic min/max calibration: top level.
// Depends on tan_pkg and touch_autocal_normalizer_macros.svh.
//
// One raw touch point is taken per transfer on the in_ stream. Nonzero
// readings widen the calibration limits at once; then each axis is scaled by
// one shared multiplier and one shared restoring divider (one quotient bit per
// cycle, 21 bits), x first and y second; y is clamped to the last screen row,
// and the point is rotated for the screen_rotation register. Per axis a
// multiply step is followed by the divide steps, then the output register is
// loaded. in_tready is low meanwhile, so a new point is not taken until the
// last one is through; a full output register adds a stall until out_tready.
// A finished result waits in the output register, so the next point is taken
// while it is pending. cfg_ready is always high.
`include "touch_autocal_normalizer_macros.svh"

module touch_autocal_normalizer #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: raw_x[9:0], raw_y[19:10], zero fill above
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: screen_x[10:0], screen_y[21:11], x_low_now[31:22],
  //            x_high_now[41:32], y_low_now[51:42], y_high_now[61:52], zero fill
  // out_tuser: limits_changed[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic        out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  localparam int RawW  = tan_pkg::RawW;
  localparam int OutW  = tan_pkg::OutW;
  localparam int CalcW = tan_pkg::CalcW;
  localparam int TopW  = tan_pkg::TopW;
  localparam int ProdW = tan_pkg::ProdW;
  localparam int CntW  = tan_pkg::CntW;

  localparam logic [TopW-1:0] TopX = TopW'(SCREEN_WIDTH - 1);
  localparam logic [TopW-1:0] TopY = TopW'(SCREEN_HEIGHT + tan_pkg::YOvershoot);
  localparam logic signed [CalcW-1:0] WMax = CalcW'(SCREEN_WIDTH - 1);
  localparam logic signed [CalcW-1:0] HMax = CalcW'(SCREEN_HEIGHT - 1);
  localparam logic signed [CalcW-1:0] HLim = CalcW'(SCREEN_HEIGHT);

  tan_pkg::state_t state_r, state_nxt;
  tan_pkg::rot_t   rot_r;

  logic [RawW-1:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic [RawW-1:0] x_low_nxt, x_high_nxt, y_low_nxt, y_high_nxt;
  logic            chg_x, chg_y;
  logic [RawW-1:0] raw_x_r, raw_y_r;
  logic [RawW-1:0] in_raw_x, in_raw_y;
  logic            changed_r;
  logic            axis_r;      // 0: x pass, 1: y pass
  logic            neg_r;

  logic [CntW-1:0]  cnt_r;
  logic [RawW-1:0]  rem_r;
  logic [ProdW-1:0] quo_r;

  logic [RawW-1:0]  sel_raw, sel_low, sel_high, span;
  logic [TopW-1:0]  sel_top;
  logic [RawW:0]    diff;
  logic [RawW-1:0]  diff_mag;
  logic [ProdW-1:0] product;
  logic [RawW:0]    shifted;
  logic [RawW+1:0]  trial;
  logic             ge;
  logic [RawW-1:0]  rem_nxt;
  logic [ProdW-1:0] quo_nxt;
  logic             div_last;
  logic signed [CalcW-1:0] q_signed;
  logic signed [CalcW-1:0] sx_r, sy_r, sy_clamp, ox, oy;

  logic in_fire, load_out, do_mul, do_div;

  logic            out_valid_r;
  logic [63:0]     out_data_r;
  logic            out_user_r;

  assign in_raw_x = in_tdata[RawW-1:0];
  assign in_raw_y = in_tdata[2*RawW-1:RawW];

  // widen the limits with nonzero readings
  always_comb begin
    x_low_nxt  = x_low_r;
    x_high_nxt = x_high_r;
    y_low_nxt  = y_low_r;
    y_high_nxt = y_high_r;
    chg_x = 1'b0;
    chg_y = 1'b0;
    if (in_raw_x != '0) begin
      if (in_raw_x < x_low_r) begin
        x_low_nxt = in_raw_x;
        chg_x = 1'b1;
      end
      if (in_raw_x > x_high_r) begin
        x_high_nxt = in_raw_x;
        chg_x = 1'b1;
      end
    end
    if (in_raw_y != '0) begin
      if (in_raw_y < y_low_r) begin
        y_low_nxt = in_raw_y;
        chg_y = 1'b1;
      end
      if (in_raw_y > y_high_r) begin
        y_high_nxt = in_raw_y;
        chg_y = 1'b1;
      end
    end
  end

  // shared multiplier and divider step
  always_comb begin
    sel_raw  = axis_r ? raw_y_r  : raw_x_r;
    sel_low  = axis_r ? y_low_r  : x_low_r;
    sel_high = axis_r ? y_high_r : x_high_r;
    sel_top  = axis_r ? TopY : TopX;
    span     = sel_high - sel_low;
    diff     = {1'b0, sel_raw} - {1'b0, sel_low};
    diff_mag = diff[RawW] ? RawW'(-diff) : diff[RawW-1:0];
    product  = ProdW'(diff_mag) * ProdW'(sel_top);
    shifted  = {rem_r, quo_r[ProdW-1]};
    trial    = {1'b0, shifted} - {2'b00, span};
    ge       = !trial[RawW+1];
    rem_nxt  = ge ? trial[RawW-1:0] : shifted[RawW-1:0];
    quo_nxt  = {quo_r[ProdW-2:0], ge};
    div_last = (cnt_r == CntW'(tan_pkg::DivBits - 1));
    q_signed = neg_r ? -CalcW'(quo_nxt[TopW-1:0]) : CalcW'(quo_nxt[TopW-1:0]);
  end

  // clamp y and rotate
  always_comb begin
    sy_clamp = (sy_r >= HLim) ? HMax : sy_r;
    unique case (rot_r)
      tan_pkg::ROT_90: begin
        ox = HMax - sy_clamp;
        oy = sx_r;
      end
      tan_pkg::ROT_180: begin
        ox = WMax - sx_r;
        oy = HMax - sy_clamp;
      end
      tan_pkg::ROT_270: begin
        ox = sy_clamp;
        oy = WMax - sx_r;
      end
      default: begin
        ox = sx_r;
        oy = sy_clamp;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tan_pkg::ST_IDLE:   if (in_tvalid) state_nxt = tan_pkg::ST_MUL;
      tan_pkg::ST_MUL:    state_nxt = tan_pkg::ST_DIV;
      tan_pkg::ST_DIV: begin
        if (div_last) state_nxt = axis_r ? tan_pkg::ST_FINISH : tan_pkg::ST_MUL;
      end
      tan_pkg::ST_FINISH: if (!out_valid_r || out_tready) state_nxt = tan_pkg::ST_IDLE;
      default:            state_nxt = tan_pkg::ST_IDLE;
    endcase
  end

  // control decodes
  always_comb begin
    in_tready = (state_r == tan_pkg::ST_IDLE);
    cfg_ready = 1'b1;
    in_fire   = in_tvalid && in_tready;
    do_mul    = (state_r == tan_pkg::ST_MUL);
    do_div    = (state_r == tan_pkg::ST_DIV);
    load_out  = (state_r == tan_pkg::ST_FINISH) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tan_pkg::ST_IDLE;
      rot_r       <= tan_pkg::ROT_0;
      x_low_r     <= tan_pkg::XLowReset;
      x_high_r    <= tan_pkg::XHighReset;
      y_low_r     <= tan_pkg::YLowReset;
      y_high_r    <= tan_pkg::YHighReset;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) rot_r <= tan_pkg::rot_t'(cfg_data);
      if (in_fire) begin
        x_low_r  <= x_low_nxt;
        x_high_r <= x_high_nxt;
        y_low_r  <= y_low_nxt;
        y_high_r <= y_high_nxt;
        axis_r   <= 1'b0;
      end
      if (do_mul) cnt_r <= '0;
      if (do_div) begin
        cnt_r <= cnt_r + CntW'(1);
        if (div_last) axis_r <= 1'b1;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw_x_r   <= in_raw_x;
      raw_y_r   <= in_raw_y;
      changed_r <= chg_x || chg_y;
    end
    if (do_mul) begin
      neg_r <= diff[RawW];
      quo_r <= product;
      rem_r <= '0;
    end
    if (do_div) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      if (div_last) begin
        if (axis_r) sy_r <= q_signed;
        else        sx_r <= q_signed;
      end
    end
    if (load_out) begin
      out_data_r <= {2'b00, y_high_r, y_low_r, x_high_r, x_low_r,
                     oy[OutW-1:0], ox[OutW-1:0]};
      out_user_r <= changed_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `TAN_ASSERT(a_span_pos, clk, rst_n, (x_low_r < x_high_r) && (y_low_r < y_high_r), "calibration span not positive")
  `TAN_ASSERT_NEXT(a_start_x, clk, rst_n, in_fire, (state_r == tan_pkg::ST_MUL) && !axis_r, "accepted point did not start on x")
  `TAN_ASSERT(a_finish_y, clk, rst_n, (state_r == tan_pkg::ST_FINISH) |-> axis_r, "finish reached before y pass")

endmodule
